// ----- src/bmp_gray_downscale_renderer_unit_macros.svh -----
// assertion macros for the bmp gray downscale renderer
`ifndef BMP_GRAY_DOWNSCALE_RENDERER_UNIT_MACROS_SVH
`define BMP_GRAY_DOWNSCALE_RENDERER_UNIT_MACROS_SVH

// same-cycle implication
`define BGD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BGD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bgd_pkg.sv -----
// shared types and constants of the bmp gray downscale renderer
package bgd_pkg;

	localparam int DIM_W     = 12;
	localparam int COORD_W   = 13;
	localparam int GRAY_W    = 8;
	localparam int IDX_W     = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] KIND_PAL_WR   = 2'd0;
	localparam logic [1:0] KIND_PIX_GRAY = 2'd1;
	localparam logic [1:0] KIND_PIX_PAL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 3'd6;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  index;
		logic [GRAY_W-1:0] gray;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] img_width;
		logic [DIM_W-1:0] img_height;
		logic [DIM_W-1:0] win_x;
		logic [DIM_W-1:0] win_y;
		logic [DIM_W-1:0] win_width;
		logic [DIM_W-1:0] win_height;
		logic             pixel_mode;
	} cfg_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIM_W-1:0]   num;
		logic [DIM_W-1:0]   den;
		logic [COORD_W-1:0] offset_col;
		logic [COORD_W-1:0] offset_row;
	} setup_t;

	typedef struct packed {
		logic start;
		logic frame_ready;
	} back_stat_t;

endpackage

// ----- src/bgd_ram.sv -----
// generic single-write, single-read ram with registered read
module bgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/bgd_front.sv -----
// front end: gray conversion, item classification and item queue
module bgd_front import bgd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              push,
	output logic              full,
	input  logic              opcode,
	input  logic [IDX_W-1:0]  index,
	input  logic [7:0]        blue,
	input  logic [7:0]        green,
	input  logic [7:0]        red,
	output logic              head_valid,
	output item_t             head,
	input  logic              head_pop
);

	localparam int QD  = 4;
	localparam int QAW = $clog2(QD);
	localparam logic OP_PAL_WR = 1'b0;
	localparam logic [14:0] COEF_R = 15'd38;
	localparam logic [14:0] COEF_G = 15'd75;
	localparam logic [14:0] COEF_B = 15'd15;
	localparam int GRAY_SHIFT = 7;

	function automatic logic [GRAY_W-1:0] gray_of(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [14:0] sum;
		begin
			sum = 15'(r) * COEF_R + 15'(g) * COEF_G + 15'(b) * COEF_B;
			return GRAY_W'(sum >> GRAY_SHIFT);
		end
	endfunction

	item_t          item_in;
	logic           keep;
	logic           in_range;
	logic           wr;
	logic           rd;
	item_t          mem_q [QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign in_range = {1'b0, index} < 9'(PALETTE_DEPTH);

	always_comb begin
		item_in.index = index;
		item_in.gray  = gray_of(red, green, blue);
		item_in.kind  = KIND_PIX_GRAY;
		keep          = 1'b1;
		if (opcode == OP_PAL_WR) begin
			item_in.kind = KIND_PAL_WR;
			keep         = in_range;
		end else if (cfg.pixel_mode) begin
			if (in_range) begin
				item_in.kind = KIND_PIX_PAL;
			end else begin
				item_in.gray = '0;
			end
		end
	end

	assign full       = count_q == (QAW+1)'(QD);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign wr         = push && !full && keep;
	assign rd         = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

endmodule

// ----- src/bgd_setup.sv -----
// per-frame setup: scale fraction, fitted size by long division, centering offsets
module bgd_setup import bgd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   start,
	output setup_t res
);

	localparam int PROD_W    = 2 * DIM_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CMP  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OFS  = 3'd4;

	logic [2:0]         state_q;
	logic [PROD_W-1:0]  prod_a_q;
	logic [PROD_W-1:0]  prod_b_q;
	logic [PROD_W-1:0]  dividend_q;
	logic [DIM_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               wbr_q;
	logic [DIM_W-1:0]   num_q;
	logic [DIM_W-1:0]   den_q;
	logic [DIM_W-1:0]   aw_q;
	logic [DIM_W-1:0]   ah_q;
	logic [COORD_W-1:0] offset_col_q;
	logic [COORD_W-1:0] offset_row_q;

	logic               lt;
	logic [DIM_W-1:0]   num_c;
	logic [DIM_W-1:0]   den_c;
	logic [DIM_W:0]     rem_sh;
	logic               ge;
	logic [DIM_W-1:0]   rem_nx;
	logic [PROD_W-1:0]  quot_nx;
	logic [DIM_W-1:0]   wdiff;
	logic [DIM_W-1:0]   hdiff;

	always_comb begin
		lt      = prod_a_q < prod_b_q;
		num_c   = lt ? cfg.win_width : cfg.win_height;
		den_c   = lt ? cfg.img_width : cfg.img_height;
		rem_sh  = {rem_q, dividend_q[PROD_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_nx  = ge ? DIM_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIM_W-1:0];
		quot_nx = {dividend_q[PROD_W-2:0], ge};
		wdiff   = cfg.win_width - aw_q;
		hdiff   = cfg.win_height - ah_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_q        <= DIM_W'(1);
			den_q        <= DIM_W'(1);
			offset_col_q <= '0;
			offset_row_q <= '0;
			cnt_q        <= '0;
			wbr_q        <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					wbr_q <= lt;
					cnt_q <= '0;
					if (num_c >= den_c) begin
						num_q   <= DIM_W'(1);
						den_q   <= DIM_W'(1);
						state_q <= ST_OFS;
					end else begin
						num_q   <= num_c;
						den_q   <= den_c;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_OFS;
					end
				end
				ST_OFS: begin
					offset_col_q <= COORD_W'(cfg.win_x) + COORD_W'(wdiff >> 1);
					offset_row_q <= COORD_W'(cfg.win_y) + COORD_W'(hdiff >> 1);
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				prod_a_q <= PROD_W'(cfg.win_width) * PROD_W'(cfg.img_height);
				prod_b_q <= PROD_W'(cfg.win_height) * PROD_W'(cfg.img_width);
			end
			ST_CMP: begin
				rem_q      <= '0;
				dividend_q <= lt ? prod_a_q : prod_b_q;
				if (num_c >= den_c) begin
					aw_q <= cfg.img_width;
					ah_q <= cfg.img_height;
				end else if (lt) begin
					aw_q <= cfg.win_width;
				end else begin
					ah_q <= cfg.win_height;
				end
			end
			ST_DIV: begin
				rem_q      <= rem_nx;
				dividend_q <= quot_nx;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					if (wbr_q) begin
						ah_q <= quot_nx[DIM_W-1:0];
					end else begin
						aw_q <= quot_nx[DIM_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.busy       = state_q != ST_IDLE;
	assign res.done       = state_q == ST_OFS;
	assign res.num        = num_q;
	assign res.den        = den_q;
	assign res.offset_col = offset_col_q;
	assign res.offset_row = offset_row_q;

endmodule

// ----- src/bgd_back.sv -----
// back end: palette store, position stepping, gray select and result queue
module bgd_back import bgd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               restart,
	input  logic               head_valid,
	input  item_t              head,
	output logic               head_pop,
	input  setup_t             setup,
	output back_stat_t         stat,
	output logic               empty,
	input  logic               pop,
	output logic [COORD_W-1:0] dest_x,
	output logic [COORD_W-1:0] dest_y,
	output logic [GRAY_W-1:0]  gray,
	output logic               frame_end
);

	localparam int PAW = $clog2(PALETTE_DEPTH);
	localparam int OQ  = 4;
	localparam int OAW = $clog2(OQ);

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [GRAY_W-1:0]  gray;
		logic               frame_end;
	} res_t;

	logic [DIM_W-1:0] col_cnt_q;
	logic [DIM_W-1:0] row_cnt_q;
	logic [DIM_W-1:0] col_acc_q;
	logic [DIM_W-1:0] row_acc_q;
	logic [DIM_W-1:0] scol_q;
	logic [DIM_W-1:0] srow_q;
	logic             setup_done_q;

	logic               valid_s2;
	logic [COORD_W-1:0] dest_x_s2;
	logic [COORD_W-1:0] dest_y_s2;
	logic [GRAY_W-1:0]  gray_s2;
	logic               use_ram_s2;
	logic               frame_end_s2;

	res_t           oq_q [OQ];
	logic [OAW-1:0] owr_ptr_q;
	logic [OAW-1:0] ord_ptr_q;
	logic [OAW:0]   ocount_q;
	logic [OAW:0]   used;
	logic           credit;
	logic           orcv;
	res_t           res_in;
	res_t           res_out;

	logic              ram_we;
	logic              issue;
	logic              setup_start;
	logic [GRAY_W-1:0] ram_rdata;

	logic           last_col;
	logic           last_row;
	logic [DIM_W:0] col_sum;
	logic [DIM_W:0] row_sum;
	logic           col_wrap;
	logic           row_wrap;

	assign used   = ocount_q + (OAW+1)'(valid_s2);
	assign credit = used < (OAW+1)'(OQ);

	always_comb begin
		head_pop    = 1'b0;
		ram_we      = 1'b0;
		issue       = 1'b0;
		setup_start = 1'b0;
		if (head_valid) begin
			case (head.kind)
				KIND_PAL_WR: begin
					ram_we   = 1'b1;
					head_pop = 1'b1;
				end
				KIND_PIX_GRAY, KIND_PIX_PAL: begin
					if (!setup_done_q) begin
						setup_start = !setup.busy;
					end else if (credit) begin
						issue    = 1'b1;
						head_pop = 1'b1;
					end
				end
				default: begin
					head_pop = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		last_col = col_cnt_q >= cfg.img_width - 1'b1;
		last_row = row_cnt_q >= cfg.img_height - 1'b1;
		col_sum  = {1'b0, col_acc_q} + {1'b0, setup.num};
		row_sum  = {1'b0, row_acc_q} + {1'b0, setup.num};
		col_wrap = col_sum >= {1'b0, setup.den};
		row_wrap = row_sum >= {1'b0, setup.den};
	end

	bgd_ram #(
		.WIDTH(GRAY_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.index[PAW-1:0]),
		.wdata(head.gray),
		.re   (issue),
		.raddr(head.index[PAW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			col_acc_q    <= '0;
			row_acc_q    <= '0;
			scol_q       <= '0;
			srow_q       <= '0;
			setup_done_q <= 1'b0;
		end else if (restart) begin
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			col_acc_q    <= '0;
			row_acc_q    <= '0;
			scol_q       <= '0;
			srow_q       <= '0;
			setup_done_q <= 1'b0;
		end else begin
			if (setup.done) begin
				setup_done_q <= 1'b1;
			end
			if (issue) begin
				if (!last_col) begin
					col_cnt_q <= col_cnt_q + 1'b1;
					if (col_wrap) begin
						col_acc_q <= DIM_W'(col_sum - {1'b0, setup.den});
						scol_q    <= scol_q + 1'b1;
					end else begin
						col_acc_q <= col_sum[DIM_W-1:0];
					end
				end else if (!last_row) begin
					col_cnt_q <= '0;
					col_acc_q <= '0;
					scol_q    <= '0;
					row_cnt_q <= row_cnt_q + 1'b1;
					if (row_wrap) begin
						row_acc_q <= DIM_W'(row_sum - {1'b0, setup.den});
						srow_q    <= srow_q + 1'b1;
					end else begin
						row_acc_q <= row_sum[DIM_W-1:0];
					end
				end else begin
					col_cnt_q    <= '0;
					row_cnt_q    <= '0;
					col_acc_q    <= '0;
					row_acc_q    <= '0;
					scol_q       <= '0;
					srow_q       <= '0;
					setup_done_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			dest_x_s2    <= setup.offset_col + COORD_W'(scol_q);
			dest_y_s2    <= setup.offset_row + COORD_W'(srow_q);
			gray_s2      <= head.gray;
			use_ram_s2   <= head.kind == KIND_PIX_PAL;
			frame_end_s2 <= last_col && last_row;
		end
	end

	// result queue
	always_comb begin
		res_in.dest_x    = dest_x_s2;
		res_in.dest_y    = dest_y_s2;
		res_in.gray      = use_ram_s2 ? ram_rdata : gray_s2;
		res_in.frame_end = frame_end_s2;
	end

	assign empty = ocount_q == '0;
	assign orcv  = pop && !empty;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			oq_q[owr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocount_q  <= '0;
		end else begin
			if (valid_s2) begin
				owr_ptr_q <= owr_ptr_q + 1'b1;
			end
			if (orcv) begin
				ord_ptr_q <= ord_ptr_q + 1'b1;
			end
			ocount_q <= ocount_q + (OAW+1)'(valid_s2) - (OAW+1)'(orcv);
		end
	end

	assign res_out   = oq_q[ord_ptr_q];
	assign dest_x    = res_out.dest_x;
	assign dest_y    = res_out.dest_y;
	assign gray      = res_out.gray;
	assign frame_end = res_out.frame_end;

	assign stat.start       = setup_start;
	assign stat.frame_ready = setup_done_q;

endmodule

// ----- src/bmp_gray_downscale_renderer_unit.sv -----
// top level of the bmp gray downscale renderer
// Usage:
//   Input queue: drive opcode/index/blue/green/red and push; a request is taken at a
//   clock edge with push high and full low. A palette write (opcode 0) stores one gray
//   entry and gives no result; a pixel (opcode 1) gives exactly one result.
//   Result queue: while empty is low the oldest result sits on dest_x/dest_y/gray/
//   frame_end; pop with empty low takes it. frame_end marks the last pixel of a frame.
//   Config port: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Any write to a known register restarts the frame; write only while idle.
//   A pixel request passes the item queue, the issue logic and the s2 result registers
//   before its result enters the result queue. The first pixel of a frame waits for
//   setup; a 24-step long division in the setup unit computes the fitted size unless
//   the image fits unscaled. Throughput: one request per cycle once a frame is set up
//   and the result queue has room; the pixel after a frame end waits for a new setup.
//   A stalled result side fills a 4-deep result queue, then a 4-deep item queue, after
//   which full rises. Reset empties both queues, restores register defaults and
//   restarts the frame; palette contents are undefined until written.
module bmp_gray_downscale_renderer_unit import bgd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 opcode,
	input  logic [IDX_W-1:0]     index,
	input  logic [7:0]           blue,
	input  logic [7:0]           green,
	input  logic [7:0]           red,
	output logic                 empty,
	input  logic                 pop,
	output logic [COORD_W-1:0]   dest_x,
	output logic [COORD_W-1:0]   dest_y,
	output logic [GRAY_W-1:0]    gray,
	output logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

`include "bmp_gray_downscale_renderer_unit_macros.svh"

	localparam int MAX_DIM = 4096;

	function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
		begin
			if (v == '0) begin
				return DIM_W'(1);
			end else if (32'(v) > MAX_DIM - 1) begin
				return DIM_W'(MAX_DIM - 1);
			end
			return v;
		end
	endfunction

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic       cfg_restart;
	logic       head_valid;
	item_t      head;
	logic       head_pop;
	setup_t     setup_res;
	back_stat_t back_stat;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			REG_IMG_WIDTH, REG_IMG_HEIGHT, REG_WIN_X, REG_WIN_Y, REG_WIN_WIDTH,
			REG_WIN_HEIGHT, REG_PIXEL_MODE: begin
				cfg_restart = cfg_wr;
			end
			default: begin
				cfg_restart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_width  <= DIM_W'(1);
			cfg_q.img_height <= DIM_W'(1);
			cfg_q.win_x      <= '0;
			cfg_q.win_y      <= '0;
			cfg_q.win_width  <= DIM_W'(1);
			cfg_q.win_height <= DIM_W'(1);
			cfg_q.pixel_mode <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_IMG_WIDTH:  cfg_q.img_width  <= dim_of(cfg_data);
				REG_IMG_HEIGHT: cfg_q.img_height <= dim_of(cfg_data);
				REG_WIN_X:      cfg_q.win_x      <= cfg_data;
				REG_WIN_Y:      cfg_q.win_y      <= cfg_data;
				REG_WIN_WIDTH:  cfg_q.win_width  <= dim_of(cfg_data);
				REG_WIN_HEIGHT: cfg_q.win_height <= dim_of(cfg_data);
				REG_PIXEL_MODE: cfg_q.pixel_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	bgd_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.index     (index),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.head_valid(head_valid),
		.head      (head),
		.head_pop  (head_pop)
	);

	bgd_setup u_setup (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.start (back_stat.start),
		.res   (setup_res)
	);

	bgd_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.restart   (cfg_restart),
		.head_valid(head_valid),
		.head      (head),
		.head_pop  (head_pop),
		.setup     (setup_res),
		.stat      (back_stat),
		.empty     (empty),
		.pop       (pop),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.gray      (gray),
		.frame_end (frame_end)
	);

	`BGD_ASSERT_IMP(a_start_when_idle, back_stat.start, !setup_res.busy, "setup started while busy")
	`BGD_ASSERT_NXT(a_done_arms_frame, setup_res.done && !cfg_restart,
		back_stat.frame_ready && !setup_res.busy, "setup done did not arm the frame")
	`BGD_ASSERT_NXT(a_restart_disarms, cfg_restart, !back_stat.frame_ready,
		"register write did not restart the frame")

endmodule
